/* rtl/core/rpr_pkg.sv */
// ----------------------------------------------------------------------------
// rpr_pkg
// Shared types, constants and tables of the rotary position rotator.
// ----------------------------------------------------------------------------
`default_nettype none
package rpr_pkg;
  localparam int unsigned MaxPairsDef = 128;
  localparam int unsigned CordicStagesDef = 24;
  localparam int unsigned GuardBits = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned AccW = 52;
  localparam int unsigned CfgW = 17;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned QueueDepth = 4;
  localparam logic [31:0] GainQ32 = 32'd2608131496;
  localparam logic [CfgIdxW-1:0] RegHeadDim = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxPos = 1'b1;

  typedef struct packed {
    logic        err;
    logic [15:0] pos;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] freq;
  } work_t;

  function automatic logic [31:0] atan_turns(input int unsigned i);
    logic [31:0] r;
    begin
      unique case (i)
        0: r = 32'd536870912;  1: r = 32'd316933406;  2: r = 32'd167458907;
        3: r = 32'd85004756;   4: r = 32'd42667331;   5: r = 32'd21354465;
        6: r = 32'd10679838;   7: r = 32'd5340245;    8: r = 32'd2670163;
        9: r = 32'd1335087;    10: r = 32'd667544;    11: r = 32'd333772;
        12: r = 32'd166886;    13: r = 32'd83443;     14: r = 32'd41722;
        15: r = 32'd20861;     16: r = 32'd10430;     17: r = 32'd5215;
        18: r = 32'd2608;      19: r = 32'd1304;      20: r = 32'd652;
        21: r = 32'd326;       22: r = 32'd163;       23: r = 32'd81;
        24: r = 32'd41;        25: r = 32'd20;        26: r = 32'd10;
        27: r = 32'd5;         28: r = 32'd3;         29: r = 32'd1;
        30: r = 32'd1;         default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/core/rpr_ram.sv */
// ----------------------------------------------------------------------------
// rpr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rpr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/rpr_front.sv */
// ----------------------------------------------------------------------------
// rpr_front
// Classifies items: rotations are checked against the limits, held in a
// staging register while their frequency is read, then queued for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rpr_front #(
  parameter int unsigned MaxPairs = rpr_pkg::MaxPairsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output logic                    full_o,
  input  wire logic               mode_i,
  input  wire logic [6:0]         pair_index_i,
  input  wire logic [15:0]        position_i,
  input  wire logic [31:0]        x_i,
  input  wire logic [31:0]        y_i,
  input  wire logic [8:0]         head_len_i,
  input  wire logic [16:0]        max_positions_i,
  input  wire logic [31:0]        freq_i,
  output logic                    q_valid_o,
  output rpr_pkg::work_t          q_item_o,
  input  wire logic               q_pop_i
);
  import rpr_pkg::*;
  localparam int unsigned PtrW = $clog2(QueueDepth);

  work_t            fifo_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push_rot;
  work_t            item;
  logic             pair_ok;
  logic             stg_v_q;
  work_t            stg_q;
  work_t            ent;

  assign full_o = ((cnt_q + (PtrW+1)'(stg_v_q)) == (PtrW+1)'(QueueDepth));
  assign push_rot = push_i && !full_o && mode_i;
  assign pair_ok = ({1'b0, pair_index_i} < head_len_i[8:1])
                && (32'(pair_index_i) < MaxPairs);

  always_comb begin
    item.err = !pair_ok || ({1'b0, position_i} >= max_positions_i);
    item.pos = position_i;
    item.x = x_i;
    item.y = y_i;
    item.freq = '0;
  end

  // table read data arrives in the cycle after accept
  always_comb begin
    ent = stg_q;
    ent.freq = freq_i;
  end

  always_ff @(posedge clk_i) begin
    if (push_rot) begin
      stg_q <= item;
    end
    if (stg_v_q) begin
      fifo_q[wr_q] <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      stg_v_q <= push_rot;
      if (stg_v_q) begin
        wr_q <= wr_q + 1'b1;
      end
      if (q_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(stg_v_q) - (PtrW+1)'(q_pop_i);
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_item_o = fifo_q[rd_q];
endmodule
`default_nettype wire

/* rtl/core/rpr_back.sv */
// ----------------------------------------------------------------------------
// rpr_back
// Forms the phase, applies gain and a CORDIC pipeline, then rounds,
// saturates and buffers results.
// ----------------------------------------------------------------------------
`default_nettype none
module rpr_back #(
  parameter int unsigned CordicStages = rpr_pkg::CordicStagesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  rpr_pkg::work_t         q_item_i,
  output logic                   q_pop_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic [31:0]            out_x_o,
  output logic [31:0]            out_y_o,
  output logic                   error_o
);
  import rpr_pkg::*;
  localparam int unsigned Lat = CordicStages + 4;
  localparam int unsigned OD = Lat + 2;
  localparam int unsigned OPW = $clog2(OD);

  logic [OPW:0] ocnt_q, inflight_q;
  logic         take;
  logic [Lat-1:0] vld_q;

  // credit: outstanding = queued outputs + items in flight
  assign take = q_valid_i && ((ocnt_q + inflight_q) < (OPW+1)'(OD));
  assign q_pop_o = take;

  // stage 0 registers the item, then ph, gx and gy multiply pos*freq, x*K, y*K
  work_t s0_q;
  logic [31:0] ph_q;
  logic signed [63:0] gx_q, gy_q;
  logic e1_q;
  always_ff @(posedge clk_i) begin
    s0_q <= q_item_i;
    ph_q <= 32'(32'(s0_q.pos) * s0_q.freq);
    gx_q <= $signed(s0_q.x) * $signed({1'b0, GainQ32});
    gy_q <= $signed(s0_q.y) * $signed({1'b0, GainQ32});
    e1_q <= s0_q.err;
  end

  logic signed [AccW-1:0] a0, b0, ga, gb;
  always_comb begin
    ga = AccW'(gx_q >>> (32 - GuardBits));
    gb = AccW'(gy_q >>> (32 - GuardBits));
    unique case (ph_q[31:30])
      2'd0: begin a0 = ga; b0 = gb; end
      2'd1: begin a0 = -gb; b0 = ga; end
      2'd2: begin a0 = -ga; b0 = -gb; end
      default: begin a0 = gb; b0 = -ga; end
    endcase
  end

  logic signed [AccW-1:0] a_q [CordicStages+1];
  logic signed [AccW-1:0] b_q [CordicStages+1];
  logic signed [32:0]     z_q [CordicStages+1];
  logic                   e_q [CordicStages+1];
  always_ff @(posedge clk_i) begin
    a_q[0] <= a0;
    b_q[0] <= b0;
    z_q[0] <= {3'b000, ph_q[29:0]};
    e_q[0] <= e1_q;
    for (int i = 0; i < CordicStages; i++) begin
      e_q[i+1] <= e_q[i];
      if (!z_q[i][32]) begin
        a_q[i+1] <= a_q[i] - (b_q[i] >>> i);
        b_q[i+1] <= b_q[i] + (a_q[i] >>> i);
        z_q[i+1] <= z_q[i] - $signed({1'b0, atan_turns(i)});
      end else begin
        a_q[i+1] <= a_q[i] + (b_q[i] >>> i);
        b_q[i+1] <= b_q[i] - (a_q[i] >>> i);
        z_q[i+1] <= z_q[i] + $signed({1'b0, atan_turns(i)});
      end
    end
  end

  function automatic logic [31:0] fin(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] r;
    begin
      r = (v + AccW'(1 << (GuardBits-1))) >>> GuardBits;
      if (r > AccW'(64'sh7FFFFFFF)) return 32'h7FFFFFFF;
      if (r < -AccW'(64'sh80000000)) return 32'h80000000;
      return r[31:0];
    end
  endfunction

  logic [64:0] res_q;
  always_ff @(posedge clk_i) begin
    if (e_q[CordicStages]) res_q <= {1'b1, 64'd0};
    else res_q <= {1'b0, fin(a_q[CordicStages]), fin(b_q[CordicStages])};
  end

  // valid pipeline: take -> s0 -> ph -> a0 -> CORDIC stages -> res
  logic res_v;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat-2:0], take};
  end
  assign res_v = vld_q[Lat-1];

  logic [64:0] ofifo_q [OD];
  logic [OPW-1:0] owr_q, ord_q;
  logic deq;
  assign empty_o = (ocnt_q == '0);
  assign deq = pop_i && !empty_o;
  always_ff @(posedge clk_i) begin
    if (res_v) ofifo_q[owr_q] <= res_q;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q <= '0; ord_q <= '0; ocnt_q <= '0; inflight_q <= '0;
    end else begin
      if (res_v) owr_q <= (owr_q == OPW'(OD-1)) ? '0 : owr_q + 1'b1;
      if (deq) ord_q <= (ord_q == OPW'(OD-1)) ? '0 : ord_q + 1'b1;
      ocnt_q <= ocnt_q + (OPW+1)'(res_v) - (OPW+1)'(deq);
      inflight_q <= inflight_q + (OPW+1)'(take) - (OPW+1)'(res_v);
    end
  end
  assign error_o = ofifo_q[ord_q][64];
  assign out_x_o = ofifo_q[ord_q][63:32];
  assign out_y_o = ofifo_q[ord_q][31:0];
endmodule
`default_nettype wire

/* rtl/core/rotary_position_rotator.sv */
// ----------------------------------------------------------------------------
// rotary_position_rotator
// Rotates one (even, odd) head vector pair by the rotary position angle.
// ----------------------------------------------------------------------------
// Input is a queue: an item enters on push_i when full_o is low. Mode 0
// loads freq_turns_i into the frequency table at pair_index_i and gives no
// result; mode 1 rotates (x_i, y_i). Results leave as a queue: out_x_o,
// out_y_o and error_o show the oldest result while empty_o is low and
// retire on pop_i. One item per cycle is accepted while full_o is low. From
// accept to empty_o low, a rotation passes the frequency read, multiply,
// gain, CORDIC pipeline (one micro-rotation per stage) and rounding stages.
// Reset empties the queues and loads head_len 128 and max_positions 4096;
// the frequency table is not cleared. When pop_i stays low, results collect
// in the output buffer, then the input queue fills and full_o rises.
// ----------------------------------------------------------------------------
`default_nettype none
module rotary_position_rotator #(
  parameter int unsigned MAX_PAIRS     = rpr_pkg::MaxPairsDef,
  parameter int unsigned CORDIC_STAGES = rpr_pkg::CordicStagesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic        mode_i,
  input  wire logic [6:0]  pair_index_i,
  input  wire logic [15:0] position_i,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  input  wire logic [31:0] freq_turns_i,
  input  wire logic        cfg_we_i,
  input  wire logic [rpr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rpr_pkg::CfgW-1:0]    cfg_data_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [31:0]      out_x_o,
  output logic [31:0]      out_y_o,
  output logic             error_o
);
  import rpr_pkg::*;
  localparam int unsigned AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic [8:0]  head_len_q;
  logic [16:0] max_pos_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_len_q <= 9'd128;
      max_pos_q <= 17'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegHeadDim: head_len_q <= cfg_data_i[8:0];
        default:    max_pos_q <= cfg_data_i;
      endcase
    end
  end

  logic   q_valid, q_pop;
  work_t  q_item;
  logic [31:0] freq;

  // rotations read the table at accept, so later loads never overtake them
  logic push_rot, load;
  assign push_rot = push_i && !full_o && mode_i;
  assign load = push_i && !full_o && !mode_i && (32'(pair_index_i) < MAX_PAIRS);

  rpr_front #(.MaxPairs(MAX_PAIRS)) u_front (
    .clk_i, .rst_ni, .push_i, .full_o, .mode_i, .pair_index_i, .position_i,
    .x_i, .y_i,
    .head_len_i(head_len_q), .max_positions_i(max_pos_q), .freq_i(freq),
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  rpr_ram #(.Width(32), .Depth(MAX_PAIRS)) u_ram (
    .clk_i, .we_i(load), .waddr_i(AW'(pair_index_i)), .wdata_i(freq_turns_i),
    .re_i(push_rot), .raddr_i(AW'(pair_index_i)), .rdata_o(freq)
  );

  rpr_back #(.CordicStages(CORDIC_STAGES)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item),
    .q_pop_o(q_pop), .empty_o, .pop_i, .out_x_o, .out_y_o, .error_o
  );
endmodule
`default_nettype wire
